>>> design/css_pkg.sv
// ----------------------------------------------------------------------------
// css_pkg
// Shared types, action codes and cascade key helper for the priority store.
// ----------------------------------------------------------------------------
package css_pkg;

    // Action codes
    localparam logic [2:0] ACT_APPLY     = 3'd0;
    localparam logic [2:0] ACT_REM_DECL  = 3'd1;
    localparam logic [2:0] ACT_QUERY     = 3'd2;
    localparam logic [2:0] ACT_REM_PROP  = 3'd3;
    localparam logic [2:0] ACT_CLEAR     = 3'd4;

    // Origin codes
    localparam logic [2:0] ORG_UA        = 3'd0;
    localparam logic [2:0] ORG_USER      = 3'd1;
    localparam logic [2:0] ORG_AUTHOR    = 3'd2;
    localparam logic [2:0] ORG_ANIMATION = 3'd3;
    localparam logic [2:0] ORG_TRANSIT   = 3'd4;

    localparam logic [31:0] ORDER_START  = 32'h0000_0001;

    // One stored declaration
    typedef struct packed {
        logic [15:0] tag;
        logic [27:0] rank;
        logic [31:0] ord;
    } t_entry;

    // Map origin and importance to the 3-bit cascade level
    function automatic logic [2:0] cascade_key(input logic [2:0] origin, input logic imp);
        logic [2:0] o;
        logic [2:0] k;
        o = origin;
        if (o > ORG_TRANSIT) o = ORG_AUTHOR;
        if (!imp) begin
            k = (o >= ORG_ANIMATION) ? 3'd3 : o;
        end else begin
            k = (o >= ORG_ANIMATION) ? 3'd4 : (3'd7 - o);
        end
        return k;
    endfunction

endpackage

>>> design/css_ram.sv
// ----------------------------------------------------------------------------
// css_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module css_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/css_cascade_priority_store.sv
// ----------------------------------------------------------------------------
// css_cascade_priority_store
// Per-property lists of CSS declarations kept in descending cascade order.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_ready  | i_action .. i_element_count
//  result  | out       | o_valid / i_ready  | o_ok .. o_dropped
//
//  One transaction at a time. From acceptance, a query or a property removal
//  goes through property index reduction (when NUM_PROPS is below 256), the
//  length read, dispatch, the length write and, for a non-empty list, the
//  head read. An apply adds a head check, a walk up from the tail and an insert;
//  a declaration removal adds a scan and a shift of the entries below the match,
//  all on the single entry RAM port. Reset and clear all sweep the length store, not ready.
//  A result waiting on i_ready holds the sequencer in its final state.
// ----------------------------------------------------------------------------
module css_cascade_priority_store import css_pkg::*; #(
    parameter int NUM_PROPS  = 256,
    parameter int LIST_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_property_req,
    input  logic [15:0] i_decl_tag,
    input  logic [2:0]  i_origin,
    input  logic        i_important,
    input  logic        i_inline_style,
    input  logic [7:0]  i_id_count,
    input  logic [7:0]  i_class_count,
    input  logic [7:0]  i_element_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_ok,
    output logic        o_winner_present,
    output logic [15:0] o_winner_tag,
    output logic [3:0]  o_entry_count,
    output logic        o_dropped
);

    localparam int PW = $clog2(NUM_PROPS);
    localparam int AW = $clog2(NUM_PROPS * LIST_DEPTH);
    localparam int IW = $clog2(LIST_DEPTH);
    localparam int SW = $clog2(LIST_DEPTH + 1);
    localparam int CW = SW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
    localparam logic [10:0]   NPROP_C = 11'(NUM_PROPS);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0_0000_0000_0001,
        S_MOD  = 13'b0_0000_0000_0010,
        S_LEN  = 13'b0_0000_0000_0100,
        S_DISP = 13'b0_0000_0000_1000,
        S_AHD  = 13'b0_0000_0001_0000,
        S_ASC  = 13'b0_0000_0010_0000,
        S_AINS = 13'b0_0000_0100_0000,
        S_RSC  = 13'b0_0000_1000_0000,
        S_RSH  = 13'b0_0001_0000_0000,
        S_LWR  = 13'b0_0010_0000_0000,
        S_HWT  = 13'b0_0100_0000_0000,
        S_DONE = 13'b0_1000_0000_0000,
        S_CLR  = 13'b1_0000_0000_0000
    } t_state;

    t_state          r_state, n_state;
    logic [2:0]      r_act, n_act;
    logic [7:0]      r_pm, n_pm;
    t_entry          r_new, n_new;
    logic [AW-1:0]   r_base, n_base;
    logic [SW-1:0]   r_n, n_n;
    logic [IW-1:0]   r_k, n_k;
    logic [31:0]     r_cnt, n_cnt;
    logic            r_ok, n_ok;
    logic            r_drop, n_drop;
    logic [15:0]     r_head, n_head;
    logic            r_pres, n_pres;
    logic [PW-1:0]   r_sw, n_sw;
    logic            r_o_valid, n_o_valid;
    logic            r_o_ok, n_o_ok;
    logic            r_o_wp, n_o_wp;
    logic [15:0]     r_o_tag, n_o_tag;
    logic [3:0]      r_o_cnt, n_o_cnt;
    logic            r_o_drop, n_o_drop;

    logic [PW-1:0]   p;
    logic            e_we;
    logic [AW-1:0]   e_wa, e_ra;
    t_entry          e_wd, e_q;
    logic            l_we;
    logic [PW-1:0]   l_wa;
    logic [SW:0]     l_wd;
    logic [SW:0]     l_q;
    logic [5:0]      n_ext;
    logic            q_lt_new;

    assign p        = PW'(r_pm);
    assign n_ext    = 6'(r_n);
    assign q_lt_new = {e_q.rank, e_q.ord} < {r_new.rank, r_new.ord};

    css_ram #(.WIDTH($bits(t_entry)), .DEPTH(NUM_PROPS * LIST_DEPTH)) u_entries (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_wa),
        .i_wdata (e_wd),
        .i_raddr (e_ra),
        .o_rdata (e_q)
    );

    // Length store: present flag over list length, one word per property
    css_ram #(.WIDTH(SW + 1), .DEPTH(NUM_PROPS)) u_lengths (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_wa),
        .i_wdata (l_wd),
        .i_raddr (p),
        .o_rdata (l_q)
    );

    // Sequencer and shared compare unit
    always_comb begin
        n_state   = r_state;
        n_act     = r_act;
        n_pm      = r_pm;
        n_new     = r_new;
        n_base    = r_base;
        n_n       = r_n;
        n_k       = r_k;
        n_cnt     = r_cnt;
        n_ok      = r_ok;
        n_drop    = r_drop;
        n_head    = r_head;
        n_pres    = r_pres;
        n_sw      = r_sw;
        n_o_valid = r_o_valid;
        n_o_ok    = r_o_ok;
        n_o_wp    = r_o_wp;
        n_o_tag   = r_o_tag;
        n_o_cnt   = r_o_cnt;
        n_o_drop  = r_o_drop;
        e_we      = 1'b0;
        e_wa      = r_base;
        e_wd      = r_new;
        e_ra      = r_base;
        l_we      = 1'b0;
        l_wa      = p;
        l_wd      = {r_pres, r_n};

        // Release the result register
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_act      = i_action;
                    n_pm       = i_property_req;
                    n_new.tag  = i_decl_tag;
                    n_new.rank = {cascade_key(i_origin, i_important), i_inline_style,
                                  i_id_count, i_class_count, i_element_count};
                    n_ok       = 1'b0;
                    n_drop     = 1'b0;
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                // Reduce the property id one subtraction a cycle
                if ({3'b000, r_pm} >= NPROP_C) begin
                    n_pm = r_pm - 8'(NUM_PROPS);
                end else begin
                    n_base  = AW'(p) * AW'(LIST_DEPTH);
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                n_n     = l_q[SW-1:0];
                n_pres  = l_q[SW];
                n_state = S_DISP;
            end
            S_DISP: begin
                n_state = S_LWR;
                case (r_act)
                    ACT_APPLY: begin
                        n_new.ord = r_cnt;
                        n_cnt     = r_cnt + 32'd1;
                        n_pres    = 1'b1;
                        n_ok      = 1'b1;
                        n_drop    = (CW'(r_n) == DEPTH_C);
                        if (CW'(r_n) != DEPTH_C) n_n = r_n + SW'(1);
                        if (r_n != '0) begin
                            n_state = S_AHD;
                        end else begin
                            n_k     = '0;
                            n_state = S_AINS;
                        end
                    end
                    ACT_REM_DECL: begin
                        if (r_pres && r_n != '0) begin
                            n_k     = '0;
                            n_state = S_RSC;
                        end
                    end
                    ACT_QUERY: begin
                        n_ok = r_pres;
                    end
                    ACT_REM_PROP: begin
                        n_ok   = r_pres;
                        n_pres = 1'b0;
                        n_n    = '0;
                    end
                    ACT_CLEAR: begin
                        n_pres  = 1'b0;
                        n_cnt   = ORDER_START;
                        n_n     = '0;
                        n_ok    = 1'b1;
                        n_head  = '0;
                        n_sw    = '0;
                        n_state = S_CLR;
                    end
                    default: begin
                        n_ok = 1'b0;
                    end
                endcase
            end
            S_AHD: begin
                // Head equal in rank and order: replace it in place
                if (e_q.rank == r_new.rank && e_q.ord == r_new.ord) begin
                    e_we    = 1'b1;
                    e_wa    = r_base;
                    n_n     = r_drop ? r_n : r_n - SW'(1);
                    n_drop  = 1'b0;
                    n_state = S_LWR;
                end else begin
                    n_k     = IW'((r_drop ? CW'(r_n) : CW'(r_n) - CW'(1)) - CW'(1));
                    e_ra    = r_base + AW'(r_drop ? CW'(r_n) - CW'(1) : CW'(r_n) - CW'(2));
                    n_state = S_ASC;
                end
            end
            S_ASC: begin
                // Walk up from the tail, shifting weaker entries down
                if (q_lt_new) begin
                    if (CW'(r_k) + CW'(1) < DEPTH_C) begin
                        e_we = 1'b1;
                        e_wa = r_base + AW'(CW'(r_k) + CW'(1));
                        e_wd = e_q;
                    end
                    if (r_k == '0) begin
                        n_state = S_AINS;
                    end else begin
                        n_k  = r_k - IW'(1);
                        e_ra = r_base + AW'(r_k - IW'(1));
                    end
                end else if (CW'(r_k) + CW'(1) < DEPTH_C) begin
                    n_k     = IW'(CW'(r_k) + CW'(1));
                    n_state = S_AINS;
                end else begin
                    n_state = S_LWR;
                end
            end
            S_AINS: begin
                e_we    = 1'b1;
                e_wa    = r_base + AW'(r_k);
                n_state = S_LWR;
            end
            S_RSC: begin
                // Scan for the first entry with the tag
                if (e_q.tag == r_new.tag) begin
                    n_ok = 1'b1;
                    n_n  = r_n - SW'(1);
                    if (CW'(r_k) + CW'(1) < CW'(r_n)) begin
                        e_ra    = r_base + AW'(CW'(r_k) + CW'(1));
                        n_state = S_RSH;
                    end else begin
                        n_state = S_LWR;
                    end
                end else if (CW'(r_k) + CW'(1) < CW'(r_n)) begin
                    n_k  = IW'(CW'(r_k) + CW'(1));
                    e_ra = r_base + AW'(CW'(r_k) + CW'(1));
                end else begin
                    n_state = S_LWR;
                end
            end
            S_RSH: begin
                // Promote the next entry up one slot
                e_we = 1'b1;
                e_wa = r_base + AW'(r_k);
                e_wd = e_q;
                if (CW'(r_k) + CW'(1) < CW'(r_n)) begin
                    n_k  = IW'(CW'(r_k) + CW'(1));
                    e_ra = r_base + AW'(CW'(r_k) + CW'(2));
                end else begin
                    n_state = S_LWR;
                end
            end
            S_LWR: begin
                l_we = 1'b1;
                e_ra = r_base;
                if (r_n != '0) begin
                    n_state = S_HWT;
                end else begin
                    n_head  = '0;
                    n_state = S_DONE;
                end
            end
            S_HWT: begin
                n_head  = e_q.tag;
                n_state = S_DONE;
            end
            S_CLR: begin
                // Sweep the length store, one property a cycle
                l_we = 1'b1;
                l_wa = r_sw;
                l_wd = '0;
                if (r_sw == PW'(NUM_PROPS - 1)) begin
                    n_sw    = '0;
                    n_state = r_ok ? S_DONE : S_IDLE;
                end else begin
                    n_sw = r_sw + PW'(1);
                end
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_ok    = r_ok;
                    n_o_wp    = (r_n != '0);
                    n_o_tag   = r_head;
                    n_o_cnt   = (n_ext > 6'd15) ? 4'd15 : n_ext[3:0];
                    n_o_drop  = r_drop;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers; reset starts with a sweep of the length store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_cnt     <= ORDER_START;
            r_sw      <= '0;
            r_ok      <= 1'b0;
            r_o_valid <= 1'b0;
            r_n       <= '0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_sw      <= n_sw;
            r_ok      <= n_ok;
            r_o_valid <= n_o_valid;
            r_n       <= n_n;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_pm     <= n_pm;
        r_new    <= n_new;
        r_base   <= n_base;
        r_k      <= n_k;
        r_drop   <= n_drop;
        r_head   <= n_head;
        r_pres   <= n_pres;
        r_o_ok   <= n_o_ok;
        r_o_wp   <= n_o_wp;
        r_o_tag  <= n_o_tag;
        r_o_cnt  <= n_o_cnt;
        r_o_drop <= n_o_drop;
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_ok             = r_o_ok;
    assign o_winner_present = r_o_wp;
    assign o_winner_tag     = r_o_tag;
    assign o_entry_count    = r_o_cnt;
    assign o_dropped        = r_o_drop;

    // Checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("accepted a transaction without leaving idle");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_n) <= DEPTH_C)
        else $error("list length beyond depth");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_entry_count) <= LIST_DEPTH))
        else $error("reported entry count beyond depth");

    a_empty_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_winner_present) |-> (o_winner_tag == 16'd0))
        else $error("winner tag set on an empty list");

endmodule

>>> dv/css_cascade_priority_store_test.sv
// ----------------------------------------------------------------------------
// css_cascade_priority_store_test
// Self-checking bench for the cascade priority store. A directed table covers
// empty lists, field extremes, every action, origin and importance mapping,
// ties, full-list drops and clear all. A random phase on a few hot properties
// follows. A local cascade predictor checks each result in order, and both
// handshakes see random gaps.
// ----------------------------------------------------------------------------
module css_cascade_priority_store_test;
    import css_pkg::*;

    localparam int NPROP = 256;
    localparam int DEPTH = 8;
    localparam int RAND_ITEMS = 500;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 60;

    // Action and origin codes the package leaves unnamed
    localparam logic [2:0] ACT_RSVD5 = 3'd5;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;
    localparam logic [2:0] ORG_RSVD7 = 3'd7;

    typedef struct packed {
        logic [2:0]  act;
        logic [7:0]  prop;
        logic [15:0] tag;
        logic [2:0]  org;
        logic        imp;
        logic        inl;
        logic [7:0]  ids;
        logic [7:0]  cls;
        logic [7:0]  els;
    } t_cmd;

    typedef struct packed {
        logic        ok;
        logic        present;
        logic [15:0] wtag;
        logic [3:0]  count;
        logic        dropped;
    } t_res;

    typedef struct packed {
        t_cmd cmd;
        logic fixed;
        t_res res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_action;
    logic [7:0]  i_property_req;
    logic [15:0] i_decl_tag;
    logic [2:0]  i_origin;
    logic        i_important;
    logic        i_inline_style;
    logic [7:0]  i_id_count;
    logic [7:0]  i_class_count;
    logic [7:0]  i_element_count;
    logic        o_valid;
    logic        i_ready;
    logic        o_ok;
    logic        o_winner_present;
    logic [15:0] o_winner_tag;
    logic [3:0]  o_entry_count;
    logic        o_dropped;

    css_cascade_priority_store dut (.*);

    // Predictor state
    logic [15:0] pr_tag  [NPROP][DEPTH];
    logic [27:0] pr_rank [NPROP][DEPTH];
    logic [31:0] pr_ord  [NPROP][DEPTH];
    int          pr_len  [NPROP];
    bit          pr_here [NPROP];
    logic [31:0] pr_counter;

    t_res   pending_results[$];
    t_row   directed[$];
    int     mismatches;
    int     idle_cycles;
    bit     stim_done;
    logic [7:0] hot_props[4];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Walk one transaction through the cascade lists
    function automatic t_res cascade_predict(t_cmd c);
        t_res r;
        int p, n, pos;
        logic [27:0] rank;
        logic [31:0] ord;
        logic [2:0] o;
        logic [2:0] key;
        r = '0;
        p = c.prop;
        n = pr_len[p];
        case (c.act)
            ACT_APPLY: begin
                o = (c.org > ORG_TRANSIT) ? ORG_AUTHOR : c.org;
                if (!c.imp) key = (o >= ORG_ANIMATION) ? 3'd3 : o;
                else key = (o >= ORG_ANIMATION) ? 3'd4 : 3'd7 - o;
                rank = {key, c.inl, c.ids, c.cls, c.els};
                ord = pr_counter;
                pr_counter = pr_counter + 32'd1;
                pr_here[p] = 1'b1;
                r.ok = 1'b1;
                if (n > 0 && {pr_rank[p][0], pr_ord[p][0]} == {rank, ord}) begin
                    pr_tag[p][0] = c.tag;
                end else begin
                    pos = 0;
                    while (pos < n && {pr_rank[p][pos], pr_ord[p][pos]} >= {rank, ord})
                        pos++;
                    if (n == DEPTH) r.dropped = 1'b1;
                    if (pos < DEPTH) begin
                        for (int k = (n == DEPTH) ? n - 1 : n; k > pos; k--) begin
                            pr_tag[p][k]  = pr_tag[p][k-1];
                            pr_rank[p][k] = pr_rank[p][k-1];
                            pr_ord[p][k]  = pr_ord[p][k-1];
                        end
                        pr_tag[p][pos]  = c.tag;
                        pr_rank[p][pos] = rank;
                        pr_ord[p][pos]  = ord;
                        if (n < DEPTH) n++;
                    end
                end
            end
            ACT_REM_DECL: begin
                if (pr_here[p]) begin
                    for (int i = 0; i < n; i++) begin
                        if (pr_tag[p][i] == c.tag) begin
                            for (int k = i; k + 1 < n; k++) begin
                                pr_tag[p][k]  = pr_tag[p][k+1];
                                pr_rank[p][k] = pr_rank[p][k+1];
                                pr_ord[p][k]  = pr_ord[p][k+1];
                            end
                            n--;
                            r.ok = 1'b1;
                            break;
                        end
                    end
                end
            end
            ACT_QUERY: r.ok = pr_here[p];
            ACT_REM_PROP: begin
                r.ok = pr_here[p];
                pr_here[p] = 1'b0;
                n = 0;
            end
            ACT_CLEAR: begin
                foreach (pr_len[i]) pr_len[i] = 0;
                foreach (pr_here[i]) pr_here[i] = 1'b0;
                pr_counter = ORDER_START;
                n = 0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        pr_len[p] = n;
        r.present = (n > 0);
        r.wtag = (n > 0) ? pr_tag[p][0] : 16'h0;
        r.count = n[3:0];
        return r;
    endfunction

    // Present one transaction, hold it until taken, then idle a random gap
    task automatic send(t_cmd c, bit fixed, t_res fixed_res);
        t_res r;
        int gap;
        i_valid         <= 1'b1;
        i_action        <= c.act;
        i_property_req  <= c.prop;
        i_decl_tag      <= c.tag;
        i_origin        <= c.org;
        i_important     <= c.imp;
        i_inline_style  <= c.inl;
        i_id_count      <= c.ids;
        i_class_count   <= c.cls;
        i_element_count <= c.els;
        do @(posedge i_clk); while (!o_ready);
        r = cascade_predict(c);
        pending_results.push_back(fixed ? fixed_res : r);
        gap = ($urandom_range(0, 9) < 5) ? 0 :
              ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_cmd mk(logic [2:0] a, logic [7:0] p, logic [15:0] t, logic [2:0] o,
                                logic im, logic il, logic [7:0] d, logic [7:0] cl,
                                logic [7:0] e);
        t_cmd c;
        c = '{a, p, t, o, im, il, d, cl, e};
        return c;
    endfunction

    function automatic t_row row(t_cmd c);
        t_row rw;
        rw.cmd = c;
        rw.fixed = 1'b0;
        rw.res = '0;
        return rw;
    endfunction

    function automatic t_row row_exp(t_cmd c, t_res r);
        t_row rw;
        rw.cmd = c;
        rw.fixed = 1'b1;
        rw.res = r;
        return rw;
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int sel;
        int p;
        c.prop = ($urandom_range(0, 9) < 8) ? hot_props[$urandom_range(0, 3)]
                                            : 8'($urandom_range(0, 255));
        sel = $urandom_range(0, 99);
        c.act = (sel < 55) ? ACT_APPLY : (sel < 78) ? ACT_REM_DECL : (sel < 88) ? ACT_QUERY :
                (sel < 94) ? ACT_REM_PROP : (sel < 96) ? ACT_CLEAR
                           : 3'($urandom_range(ACT_RSVD5, ACT_RSVD7));
        p = c.prop;
        // Removes mostly target a tag that is actually stored
        if (c.act == ACT_REM_DECL && pr_len[p] > 0 && $urandom_range(0, 3) != 0)
            c.tag = pr_tag[p][$urandom_range(0, pr_len[p] - 1)];
        else if ($urandom_range(0, 1) == 0)
            c.tag = 16'($urandom_range(0, 15));
        else
            c.tag = 16'($urandom);
        c.org = 3'($urandom_range(0, 7));
        c.imp = 1'($urandom);
        c.inl = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 2) == 0) begin
            c.ids = 8'($urandom);
            c.cls = 8'($urandom);
            c.els = 8'($urandom);
        end else begin
            c.ids = 8'($urandom_range(0, 1));
            c.cls = 8'($urandom_range(0, 2));
            c.els = 8'($urandom_range(0, 2));
        end
        return c;
    endfunction

    // Result side: random backpressure with bursts of steady ready
    initial begin
        int burst;
        i_ready <= 1'b0;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (burst > 0) begin
                burst--;
                i_ready <= 1'b1;
            end else if ($urandom_range(0, 19) == 0) begin
                burst = $urandom_range(20, 60);
                i_ready <= 1'b1;
            end else if ($urandom_range(0, 29) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end else begin
                i_ready <= ($urandom_range(0, 2) != 0);
            end
        end
    end

    // Check each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_ok, o_winner_present, o_winner_tag, o_entry_count, o_dropped};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT && !stim_done) begin
            $display("FAIL css_cascade_priority_store");
            $finish;
        end
    end

    initial begin
        t_res none;
        i_clk = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_action <= ACT_QUERY;
        i_property_req <= '0;
        i_decl_tag <= '0;
        i_origin <= ORG_UA;
        i_important <= 1'b0;
        i_inline_style <= 1'b0;
        i_id_count <= '0;
        i_class_count <= '0;
        i_element_count <= '0;
        mismatches = 0;
        idle_cycles = 0;
        stim_done = 1'b0;
        none = '0;
        foreach (pr_len[i]) pr_len[i] = 0;
        foreach (pr_here[i]) pr_here[i] = 1'b0;
        pr_counter = ORDER_START;
        hot_props = '{8'h00, 8'hFF, 8'h5A, 8'hA5};

        // Directed table: empty store, extremes, mapping, ties, drops, clear
        directed.push_back(row_exp(mk(ACT_QUERY, 8'h00, 16'h0, ORG_UA, 0, 0, 0, 0, 0), none));
        directed.push_back(row_exp(mk(ACT_REM_DECL, 8'hFF, 16'h1, ORG_UA, 0, 0, 0, 0, 0), none));
        directed.push_back(row_exp(mk(ACT_REM_PROP, 8'h05, 16'h0, ORG_UA, 0, 0, 0, 0, 0), none));
        directed.push_back(row_exp(mk(ACT_APPLY, 8'hFF, 16'hFFFF, ORG_UA, 0, 0, 0, 0, 0),
                                   '{1'b1, 1'b1, 16'hFFFF, 4'd1, 1'b0}));
        directed.push_back(row_exp(mk(ACT_APPLY, 8'hFF, 16'h0001, ORG_UA, 1, 1, 8'hFF, 8'hFF,
                                      8'hFF), '{1'b1, 1'b1, 16'h0001, 4'd2, 1'b0}));
        directed.push_back(row(mk(ACT_APPLY, 8'hFF, 16'h0002, ORG_TRANSIT, 1, 0, 1, 1, 1)));
        directed.push_back(row(mk(ACT_APPLY, 8'hFF, 16'h0003, ORG_RSVD7, 0, 1, 0, 3, 0)));
        directed.push_back(row(mk(ACT_APPLY, 8'hFF, 16'h0004, ORG_ANIMATION, 0, 0, 2, 0, 0)));
        directed.push_back(row(mk(ACT_APPLY, 8'hFF, 16'h0005, ORG_USER, 1, 0, 0, 0, 9)));
        directed.push_back(row(mk(ACT_REM_DECL, 8'hFF, 16'h0001, ORG_UA, 0, 0, 0, 0, 0)));
        directed.push_back(row(mk(ACT_QUERY, 8'hFF, 16'h0, ORG_UA, 0, 0, 0, 0, 0)));
        directed.push_back(row(mk(ACT_RSVD7, 8'hFF, 16'h0, ORG_UA, 0, 0, 0, 0, 0)));
        for (int k = 0; k < DEPTH + 1; k++)
            directed.push_back(row(mk(ACT_APPLY, 8'h03, 16'(16'h10 + k), ORG_AUTHOR, 0, 0,
                                      1, 1, 1)));
        directed.push_back(row(mk(ACT_APPLY, 8'h03, 16'h0012, ORG_UA, 0, 0, 0, 0, 0)));
        directed.push_back(row(mk(ACT_REM_DECL, 8'h03, 16'h0012, ORG_UA, 0, 0, 0, 0, 0)));
        directed.push_back(row(mk(ACT_REM_PROP, 8'h03, 16'h0, ORG_UA, 0, 0, 0, 0, 0)));
        directed.push_back(row(mk(ACT_APPLY, 8'h03, 16'h0020, ORG_UA, 0, 0, 0, 0, 0)));
        directed.push_back(row(mk(ACT_REM_DECL, 8'h03, 16'h0020, ORG_UA, 0, 0, 0, 0, 0)));
        directed.push_back(row(mk(ACT_QUERY, 8'h03, 16'h0, ORG_UA, 0, 0, 0, 0, 0)));
        directed.push_back(row_exp(mk(ACT_CLEAR, 8'hFF, 16'h0, ORG_UA, 0, 0, 0, 0, 0),
                                   '{1'b1, 1'b0, 16'h0, 4'd0, 1'b0}));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            send(directed[i].cmd, directed[i].fixed, directed[i].res);

        // Hold off the sender until the store has answered everything
        i_valid <= 1'b0;
        wait_drained();
        @(posedge i_clk);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 2) begin
                i_valid <= 1'b0;
                wait_drained();
                @(posedge i_clk);
            end
            send(random_cmd(), 1'b0, none);
        end
        i_valid <= 1'b0;

        wait_drained();
        stim_done = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS css_cascade_priority_store");
        else
            $display("FAIL css_cascade_priority_store");
        $finish;
    end

endmodule
